@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int PIDX_W   = 4;
  localparam int ISIZE_W  = 16;
  localparam int POLICY_W = 2;
  localparam int NPART_W  = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTITIONS = 1'd1;

  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  localparam logic [NPART_W-1:0] NUM_PARTITIONS_RST = 5'd16;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } pfa_state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic clear;
    logic worst;
  } pfa_cmd_t;

endpackage

@@ rtl/pfa_req_if.sv @@
interface pfa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [pfa_pkg::PIDX_W-1:0]   partition_index;
  logic [pfa_pkg::ISIZE_W-1:0]  item_size;
  logic                         last_of_round;

  modport source (
    output valid, kind, partition_index, item_size, last_of_round,
    input  ready
  );
  modport sink (
    input  valid, kind, partition_index, item_size, last_of_round,
    output ready
  );
endinterface

@@ rtl/pfa_res_if.sv @@
interface pfa_res_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [pfa_pkg::PIDX_W-1:0]  chosen_partition;

  modport source (
    output valid, granted, chosen_partition,
    input  ready
  );
  modport sink (
    input  valid, granted, chosen_partition,
    output ready
  );
endinterface

@@ rtl/pfa_cell.sv @@
module pfa_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfa_pkg::pfa_cmd_t             cmd,
  input  logic [pfa_pkg::PIDX_W-1:0]    ld_index,
  input  logic [SIZE_BITS-1:0]          ld_size,
  input  logic [SIZE_BITS-1:0]          want,
  input  logic [pfa_pkg::POLICY_W-1:0]  policy,
  input  logic [pfa_pkg::NPART_W-1:0]   num_partitions,
  input  logic [IDX_W-1:0]              commit_idx,
  input  logic                          tin_found,
  input  logic [IDX_W-1:0]              tin_idx,
  input  logic [SIZE_BITS-1:0]          tin_size,
  output logic                          tout_found,
  output logic [IDX_W-1:0]              tout_idx,
  output logic [SIZE_BITS-1:0]          tout_size
);
  import pfa_pkg::*;

  logic [SIZE_BITS-1:0] size;
  logic                 busy;
  logic                 eligible;
  logic                 better;
  logic                 take;
  logic                 ld_hit;
  logic                 commit_hit;

  assign ld_hit     = cmd.load && (int'(ld_index) == INDEX);
  assign commit_hit = cmd.commit && (int'(commit_idx) == INDEX);
  assign eligible   = (int'(num_partitions) > INDEX) && !busy && (size >= want);
  assign better     = !tin_found ||
                      ((policy == FIT_BEST) && (size < tin_size)) ||
                      ((policy == FIT_WORST) && (size > tin_size));
  assign take       = eligible && better;

  always_ff @(posedge clk) begin
    if (take) begin
      tout_found <= 1'b1;
      tout_idx   <= IDX_W'(INDEX);
      tout_size  <= size;
    end else begin
      tout_found <= tin_found;
      tout_idx   <= tin_idx;
      tout_size  <= tin_size;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_hit) begin
      size <= ld_size;
    end else if (commit_hit && cmd.worst) begin
      size <= size - want;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.clear || ld_hit) begin
      busy <= 1'b0;
    end else if (commit_hit) begin
      busy <= 1'b1;
    end
  end

endmodule

@@ rtl/partition_fit_allocator.sv @@
// Partition fit allocator. Each partition lives in one cell of a chain holding its size
// and busy mark. A load request (kind 0) writes a size and frees that partition in the
// cycle it is accepted and gives no result. An allocation request (kind 1) sends a
// candidate down the chain, one cell per cycle, through ST_SCAN until it has passed
// every cell, then ST_COMMIT commits the choice (mark busy, shrink under worst fit,
// clear all busy marks when last_of_round is set), waiting while an unread result is
// held. One request is in flight at a time; the result waits in an output register
// and a new request is taken while it waits. Write fit_policy and num_partitions only
// while idle. Sizes of partitions never loaded are undefined.
module partition_fit_allocator #(
  parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]      cfg_wdata,
  pfa_req_if.sink                        req,
  pfa_res_if.source                      res
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTITIONS);

  pfa_state_t state, state_next;

  logic [POLICY_W-1:0]  fit_policy;
  logic [NPART_W-1:0]   num_partitions;
  logic [SIZE_BITS-1:0] want;
  logic                 last;
  logic [IDX_W-1:0]     scan_cnt, scan_cnt_next;
  logic                 out_valid;
  logic                 out_granted;
  logic [PIDX_W-1:0]    out_chosen;

  logic                 accept;
  logic                 advance;
  pfa_cmd_t             cmd;
  logic [SIZE_BITS-1:0] in_size;

  logic                 tok_found [MAX_PARTITIONS+1];
  logic [IDX_W-1:0]     tok_idx   [MAX_PARTITIONS+1];
  logic [SIZE_BITS-1:0] tok_size  [MAX_PARTITIONS+1];

  assign in_size = SIZE_BITS'(req.item_size);
  assign accept  = req.valid && req.ready;
  assign advance = !out_valid || res.ready;

  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_size[0]  = '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PARTITIONS; gi++) begin : g_cell
      pfa_cell #(
        .INDEX     (gi),
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
      ) u_cell (
        .clk            (clk),
        .rst            (rst),
        .cmd            (cmd),
        .ld_index       (req.partition_index),
        .ld_size        (in_size),
        .want           (want),
        .policy         (fit_policy),
        .num_partitions (num_partitions),
        .commit_idx     (tok_idx[MAX_PARTITIONS]),
        .tin_found      (tok_found[gi]),
        .tin_idx        (tok_idx[gi]),
        .tin_size       (tok_size[gi]),
        .tout_found     (tok_found[gi+1]),
        .tout_idx       (tok_idx[gi+1]),
        .tout_size      (tok_size[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy     <= FIT_FIRST;
      num_partitions <= NUM_PARTITIONS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:     fit_policy     <= cfg_wdata[POLICY_W-1:0];
        CFG_NUM_PARTITIONS: num_partitions <= cfg_wdata[NPART_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.kind == KIND_REQUEST)) begin
      want <= in_size;
      last <= req.last_of_round;
    end
  end

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    req.ready     = 1'b0;
    cmd           = '0;
    cmd.worst     = (fit_policy == FIT_WORST);
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            state_next    = ST_SCAN;
            scan_cnt_next = '0;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == IDX_W'(MAX_PARTITIONS - 1)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (advance) begin
          cmd.commit = tok_found[MAX_PARTITIONS];
          cmd.clear  = last;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_COMMIT) && advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_COMMIT) && advance) begin
      out_granted <= tok_found[MAX_PARTITIONS];
      out_chosen  <= tok_found[MAX_PARTITIONS] ? PIDX_W'(tok_idx[MAX_PARTITIONS]) : '0;
    end
  end

  assign res.valid            = out_valid;
  assign res.granted          = out_granted;
  assign res.chosen_partition = out_chosen;

  a_rise_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_COMMIT))
    else $error("result appeared without a commit");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_chosen == '0))
    else $error("refused result carries a partition index");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> ((state == ST_SCAN) || (state == ST_COMMIT)))
    else $error("scan left without commit");

  a_commit_full_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMMIT) && ($past(state) == ST_SCAN)) |->
      ($past(scan_cnt) == IDX_W'(MAX_PARTITIONS - 1)))
    else $error("commit before the scan covered every cell");

endmodule
